### hdl/vwpr_pkg.sv
package vwpr_pkg;

  localparam int VMEM_BYTES_DEF = 32768;
  localparam int QUEUE_DEPTH    = 4;

  // register indexes on the config port
  localparam logic [2:0] CFG_GRAPHICS = 3'd0;
  localparam logic [2:0] CFG_HIRES    = 3'd1;
  localparam logic [2:0] CFG_MIXED    = 3'd2;
  localparam logic [2:0] CFG_PAGE     = 3'd3;
  localparam logic [2:0] CFG_COLOR    = 3'd4;

  // job kinds
  localparam logic [1:0] KIND_TEXT  = 2'd0;
  localparam logic [1:0] KIND_LORES = 2'd1;
  localparam logic [1:0] KIND_HIRES = 2'd2;

  typedef struct packed {
    logic graphics;
    logic hires;
    logic mixed;
    logic page;
    logic color;
  } vid_cfg_t;

  // line holds the text/lores row (low 5 bits) or the hires scanline
  typedef struct packed {
    logic [1:0] kind;
    logic       color;
    logic [5:0] col;
    logic [7:0] line;
    logic [7:0] data;
    logic [7:0] left;
    logic [7:0] right;
  } job_t;

  function automatic logic [23:0] lo_rgb(input logic [3:0] nib);
    logic [23:0] c;
    case (nib)
      4'd0:    c = {8'd0,   8'd0,   8'd0};
      4'd1:    c = {8'd227, 8'd30,  8'd96};
      4'd2:    c = {8'd96,  8'd78,  8'd189};
      4'd3:    c = {8'd255, 8'd68,  8'd253};
      4'd4:    c = {8'd0,   8'd163, 8'd96};
      4'd5:    c = {8'd156, 8'd156, 8'd156};
      4'd6:    c = {8'd20,  8'd207, 8'd253};
      4'd7:    c = {8'd208, 8'd195, 8'd255};
      4'd8:    c = {8'd96,  8'd114, 8'd3};
      4'd9:    c = {8'd255, 8'd106, 8'd60};
      4'd10:   c = {8'd156, 8'd156, 8'd156};
      4'd11:   c = {8'd255, 8'd160, 8'd208};
      4'd12:   c = {8'd20,  8'd245, 8'd60};
      4'd13:   c = {8'd208, 8'd221, 8'd141};
      4'd14:   c = {8'd114, 8'd255, 8'd208};
      default: c = {8'd255, 8'd255, 8'd255};
    endcase
    return c;
  endfunction

  function automatic logic [23:0] hi_rgb(input logic [2:0] idx);
    logic [23:0] c;
    case (idx)
      3'd1:    c = {8'd20,  8'd245, 8'd60};
      3'd2:    c = {8'd255, 8'd68,  8'd253};
      3'd3:    c = {8'd255, 8'd255, 8'd255};
      3'd5:    c = {8'd255, 8'd106, 8'd60};
      3'd6:    c = {8'd20,  8'd207, 8'd253};
      3'd7:    c = {8'd255, 8'd255, 8'd255};
      default: c = 24'd0;
    endcase
    return c;
  endfunction

  function automatic logic [23:0] grey_rgb(input logic [1:0] lvl);
    logic [23:0] c;
    case (lvl)
      2'd0:    c = 24'd0;
      2'd1:    c = {8'd85,  8'd85,  8'd85};
      2'd2:    c = {8'd171, 8'd171, 8'd171};
      default: c = {8'd255, 8'd255, 8'd255};
    endcase
    return c;
  endfunction

  // artifact colour from the (left, self, right) window
  function automatic logic [23:0] artifact(input logic [2:0] win, input logic odd,
                                           input logic hi);
    logic [23:0] c;
    case (win)
      3'd2:    c = hi_rgb({hi, ~odd, odd});
      3'd5:    c = hi_rgb({hi, odd, ~odd});
      3'd3, 3'd6, 3'd7: c = hi_rgb(3'd3);
      default: c = hi_rgb(3'd0);
    endcase
    return c;
  endfunction

endpackage

### hdl/vwpr_front.sv
module vwpr_front import vwpr_pkg::*; #(
  parameter int VIDEO_MEMORY_BYTES = VMEM_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_write_address,
  input  logic [7:0]  in_write_data,
  input  vid_cfg_t    cfg,
  output logic        push,
  output job_t        push_job,
  input  logic        full
);

  localparam int          AW    = $clog2(VIDEO_MEMORY_BYTES);
  localparam logic [16:0] DEPTH = 17'(VIDEO_MEMORY_BYTES);
  localparam logic [AW-1:0] LAST_ENTRY = AW'(VIDEO_MEMORY_BYTES - 1);

  localparam logic [1:0] ST_CLR  = 2'd0;
  localparam logic [1:0] ST_IDLE = 2'd1;
  localparam logic [1:0] ST_RD   = 2'd2;
  localparam logic [1:0] ST_NB   = 2'd3;

  logic [7:0]    mem [VIDEO_MEMORY_BYTES];
  logic [1:0]    state_r, state_nxt;
  logic [AW-1:0] clr_cnt_r;
  logic [15:0]   addr_r;
  logic [7:0]    data_r, rd_a_r, rd_b_r;

  logic          accept, in_range, changed, right_ok, slot_ok, visible;
  logic          rd_en_a, rd_en_b, mem_we;
  logic [AW-1:0] rd_addr_a, rd_addr_b, mem_wa;
  logic [7:0]    mem_wd;
  logic [6:0]    c;
  logic [5:0]    col;
  logic [1:0]    grp, kind;
  logic [4:0]    row;
  logic [7:0]    yv;
  logic          is_tl, is_hr;

  assign accept   = (state_r == ST_IDLE) && in_valid;
  assign in_stall = (state_r != ST_IDLE);
  assign in_range = {1'b0, in_write_address} < DEPTH;
  assign changed  = rd_a_r != data_r;

  assign rd_en_a   = accept || (state_r == ST_RD);
  assign rd_addr_a = (state_r == ST_RD) ? AW'(addr_r + 16'd1) : in_write_address[AW-1:0];
  assign rd_en_b   = accept;
  assign rd_addr_b = AW'(in_write_address - 16'd1);
  assign mem_we    = (state_r == ST_CLR) || ((state_r == ST_RD) && changed);
  assign mem_wa    = (state_r == ST_CLR) ? clr_cnt_r : addr_r[AW-1:0];
  assign mem_wd    = (state_r == ST_CLR) ? 8'd0 : data_r;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (rd_en_a) rd_a_r <= mem[rd_addr_a];
    if (rd_en_b) rd_b_r <= mem[rd_addr_b];
  end

  // address decode
  always_comb begin
    c       = addr_r[6:0];
    slot_ok = 1'b1;
    if (c < 7'd40) begin
      col = c[5:0];
      grp = 2'd0;
    end else if (c < 7'd80) begin
      col = 6'(c - 7'd40);
      grp = 2'd1;
    end else if (c < 7'd120) begin
      col = 6'(c - 7'd80);
      grp = 2'd2;
    end else begin
      col     = 6'd0;
      grp     = 2'd0;
      slot_ok = 1'b0;
    end
    row      = {2'b00, addr_r[9:7]} + {grp, 3'b000};
    yv       = {2'b00, addr_r[9:7], addr_r[12:10]} + {grp, 6'b000000};
    is_tl    = (addr_r >= 16'h0400) && (addr_r < 16'h0C00);
    is_hr    = (addr_r >= 16'h2000) && (addr_r < 16'h6000);
    right_ok = ({1'b0, addr_r} + 17'd1) < DEPTH;
    visible  = 1'b0;
    kind     = KIND_TEXT;
    if (is_tl) begin
      if ((addr_r < 16'h0800) != !cfg.page) begin
        visible = 1'b0;
      end else if (cfg.graphics && cfg.hires && !cfg.mixed) begin
        visible = 1'b0;
      end else if (!slot_ok) begin
        visible = 1'b0;
      end else if (cfg.graphics && cfg.hires && (row < 5'd20)) begin
        visible = 1'b0;
      end else begin
        visible = 1'b1;
        kind    = (cfg.graphics && (!cfg.mixed || (row < 5'd20))) ? KIND_LORES : KIND_TEXT;
      end
    end else if (is_hr) begin
      if (cfg.hires && cfg.graphics && ((addr_r < 16'h4000) == !cfg.page) && slot_ok &&
          !((yv >= 8'd160) && cfg.mixed)) begin
        visible = 1'b1;
        kind    = KIND_HIRES;
      end
    end
  end

  always_comb begin
    push_job.kind  = kind;
    push_job.color = cfg.color;
    push_job.col   = col;
    push_job.line  = (kind == KIND_HIRES) ? yv : {3'b000, row};
    push_job.data  = data_r;
    push_job.left  = (col == 6'd0) ? 8'd0 : rd_b_r;
    push_job.right = ((col == 6'd39) || !right_ok) ? 8'd0 : rd_a_r;
  end

  assign push = (state_r == ST_NB) && visible && !full;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLR:  if (clr_cnt_r == LAST_ENTRY) state_nxt = ST_IDLE;
      ST_IDLE: if (accept && in_range) state_nxt = ST_RD;
      ST_RD:   state_nxt = changed ? ST_NB : ST_IDLE;
      ST_NB:   if (!visible || !full) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLR;
      clr_cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLR) clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      addr_r <= in_write_address;
      data_r <= in_write_data;
    end
  end

endmodule

### hdl/vwpr_queue.sv
module vwpr_queue import vwpr_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output job_t pop_job,
  output logic empty
);

  localparam int QAW = $clog2(QUEUE_DEPTH);

  job_t         q [QUEUE_DEPTH];
  logic [QAW:0] wr_ptr_r, rd_ptr_r;

  assign empty   = wr_ptr_r == rd_ptr_r;
  assign full    = (wr_ptr_r[QAW] != rd_ptr_r[QAW]) &&
                   (wr_ptr_r[QAW-1:0] == rd_ptr_r[QAW-1:0]);
  assign pop_job = q[rd_ptr_r[QAW-1:0]];

  always_ff @(posedge clk) begin
    if (push) q[wr_ptr_r[QAW-1:0]] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop) rd_ptr_r <= rd_ptr_r + 1'b1;
    end
  end

endmodule

### hdl/vwpr_back.sv
module vwpr_back import vwpr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_empty,
  input  job_t       q_job,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [8:0] out_pixel_x,
  output logic [7:0] out_pixel_y,
  output logic [7:0] out_red,
  output logic [7:0] out_green,
  output logic [7:0] out_blue,
  output logic       out_is_text_cell,
  output logic [7:0] out_text_code,
  output logic [5:0] out_text_column,
  output logic [4:0] out_text_row,
  output logic       out_last
);

  logic       active_r, out_valid_r;
  job_t       job_r;
  logic [2:0] xi_r, yi_r;
  logic [3:0] p_r;

  logic [8:0]  x_r;
  logic [7:0]  y_r, code_r;
  logic [23:0] rgb_r;
  logic        text_r, last_r;
  logic [5:0]  tcol_r;
  logic [4:0]  trow_r;

  logic        advance, last_c;
  logic [8:0]  bx, x_c;
  logic [7:0]  y_c;
  logic [23:0] rgb_c;
  logic [3:0]  nib, end_p;
  logic [10:0] win;
  logic        odd, hi;

  assign advance = !out_valid_r || !out_stall;
  assign q_pop   = !active_r && !q_empty;

  always_comb begin
    bx    = ({3'b000, job_r.col} << 3) - {3'b000, job_r.col};
    nib   = (yi_r < 3'd4) ? job_r.data[3:0] : job_r.data[7:4];
    win   = {job_r.right[1:0], job_r.data[6:0], job_r.left[6:5]};
    odd   = job_r.col[0] ^ ~p_r[0];
    hi    = (p_r == 4'd0) ? job_r.left[7] : (p_r == 4'd8) ? job_r.right[7] : job_r.data[7];
    end_p = (job_r.color && (job_r.col != 6'd39)) ? 4'd8 : 4'd7;
    x_c    = 9'd0;
    y_c    = 8'd0;
    rgb_c  = 24'd0;
    last_c = 1'b1;
    case (job_r.kind)
      KIND_LORES: begin
        x_c    = bx + {6'd0, xi_r};
        y_c    = {job_r.line[4:0], 3'b000} + {5'd0, yi_r};
        rgb_c  = job_r.color ? lo_rgb(nib)
                 : grey_rgb((xi_r[0] ^ job_r.col[0]) ? nib[1:0] : nib[3:2]);
        last_c = (yi_r == 3'd7) && (xi_r == 3'd6);
      end
      KIND_HIRES: begin
        x_c    = bx + {5'd0, p_r} - 9'd1;
        y_c    = job_r.line;
        rgb_c  = job_r.color ? artifact(3'(win >> p_r), odd, hi)
                 : (1'(win >> (p_r + 4'd1)) ? hi_rgb(3'd3) : hi_rgb(3'd0));
        last_c = p_r == end_p;
      end
      default: begin
        last_c = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        active_r <= 1'b1;
      end else if (active_r && advance && last_c) begin
        active_r <= 1'b0;
      end
      if (advance) out_valid_r <= active_r;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      job_r <= q_job;
      xi_r  <= 3'd0;
      yi_r  <= 3'd0;
      p_r   <= (q_job.color && (q_job.col != 6'd0)) ? 4'd0 : 4'd1;
    end else if (active_r && advance) begin
      p_r <= p_r + 4'd1;
      if (xi_r == 3'd6) begin
        xi_r <= 3'd0;
        yi_r <= yi_r + 3'd1;
      end else begin
        xi_r <= xi_r + 3'd1;
      end
    end
    if (active_r && advance) begin
      text_r <= job_r.kind == KIND_TEXT;
      last_r <= last_c;
      if (job_r.kind == KIND_TEXT) begin
        x_r    <= 9'd0;
        y_r    <= 8'd0;
        rgb_r  <= 24'd0;
        code_r <= job_r.data;
        tcol_r <= job_r.col;
        trow_r <= job_r.line[4:0];
      end else begin
        x_r    <= x_c;
        y_r    <= y_c;
        rgb_r  <= rgb_c;
        code_r <= 8'd0;
        tcol_r <= 6'd0;
        trow_r <= 5'd0;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_pixel_x      = x_r;
  assign out_pixel_y      = y_r;
  assign out_red          = rgb_r[23:16];
  assign out_green        = rgb_r[15:8];
  assign out_blue         = rgb_r[7:0];
  assign out_is_text_cell = text_r;
  assign out_text_code    = code_r;
  assign out_text_column  = tcol_r;
  assign out_text_row     = trow_r;
  assign out_last         = last_r;

endmodule

### hdl/video_write_pixel_render.sv
// Video write renderer. Each CPU write transaction updates a byte store of
// VIDEO_MEMORY_BYTES entries; a write that changes a visible byte of the
// selected page produces a run of result transactions: 56 pixels for a lores
// byte (one per cycle while out_stall is low, once the job is loaded), 7 to
// 9 pixels for a hires byte, or one text cell update, the final one flagged
// by out_last. The front end steps a write that changes a byte through store
// read, write-back plus right neighbour read, and classify; a write that
// leaves the byte unchanged ends after the second step and an address
// outside the store after the first. Over a run of lores writes the pixel
// stage sets the pace. A 4-deep job queue lets the front take further
// writes while pixels are still going out. After reset a clearing pass
// zeroes the store with in_stall high; config writes are taken throughout.
module video_write_pixel_render import vwpr_pkg::*; #(
  parameter int VIDEO_MEMORY_BYTES = VMEM_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_write_address,
  input  logic [7:0]  in_write_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [8:0]  out_pixel_x,
  output logic [7:0]  out_pixel_y,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic        out_is_text_cell,
  output logic [7:0]  out_text_code,
  output logic [5:0]  out_text_column,
  output logic [4:0]  out_text_row,
  output logic        out_last,
  input  logic        cfg_write_enable,
  input  logic [2:0]  cfg_index,
  input  logic [0:0]  cfg_data
);

  vid_cfg_t cfg_r;
  logic     q_push, q_full, q_pop, q_empty;
  job_t     push_job, pop_job;

  // mode registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{graphics: 1'b0, hires: 1'b0, mixed: 1'b0, page: 1'b0, color: 1'b1};
    end else if (cfg_write_enable) begin
      case (cfg_index)
        CFG_GRAPHICS: cfg_r.graphics <= cfg_data[0];
        CFG_HIRES:    cfg_r.hires    <= cfg_data[0];
        CFG_MIXED:    cfg_r.mixed    <= cfg_data[0];
        CFG_PAGE:     cfg_r.page     <= cfg_data[0];
        CFG_COLOR:    cfg_r.color    <= cfg_data[0];
        default:      cfg_r          <= cfg_r;
      endcase
    end
  end

  // front: store, decode, neighbour fetch
  vwpr_front #(.VIDEO_MEMORY_BYTES(VIDEO_MEMORY_BYTES)) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_write_address(in_write_address),
    .in_write_data   (in_write_data),
    .cfg             (cfg_r),
    .push            (q_push),
    .push_job        (push_job),
    .full            (q_full)
  );

  vwpr_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .push_job(push_job),
    .full    (q_full),
    .pop     (q_pop),
    .pop_job (pop_job),
    .empty   (q_empty)
  );

  // back: pixel sequencer with output register
  vwpr_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .q_job           (pop_job),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_pixel_x     (out_pixel_x),
    .out_pixel_y     (out_pixel_y),
    .out_red         (out_red),
    .out_green       (out_green),
    .out_blue        (out_blue),
    .out_is_text_cell(out_is_text_cell),
    .out_text_code   (out_text_code),
    .out_text_column (out_text_column),
    .out_text_row    (out_text_row),
    .out_last        (out_last)
  );

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_push && q_full)) else $error("job pushed into full queue");

  a_text_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_is_text_cell) |-> out_last) else $error("text cell not last");

  a_pixel_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_is_text_cell) |-> (out_pixel_x < 9'd280 && out_pixel_y < 8'd192))
    else $error("pixel off screen");

endmodule

### tb/video_write_pixel_render_tb.sv
module video_write_pixel_render_tb;
  import vwpr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MEM_BYTES   = VMEM_BYTES_DEF;
  // settling allowance for the front end plus a 4-deep job queue of lores runs
  localparam int SETTLE      = 300;
  localparam int CYCLE_LIMIT = 600000;
  localparam int RAND_PER_PHASE = 13;

  typedef struct {
    logic [15:0] addr;
    logic [7:0]  data;
  } cpu_write_t;

  // one expected result transaction
  typedef struct {
    logic [8:0] x;
    logic [7:0] y;
    logic [7:0] r, g, b;
    logic       txt;
    logic [7:0] code;
    logic [5:0] tcol;
    logic [4:0] trow;
    logic       last;
  } screen_update_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [15:0] in_write_address = '0;
  logic [7:0]  in_write_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [8:0]  out_pixel_x;
  logic [7:0]  out_pixel_y;
  logic [7:0]  out_red, out_green, out_blue;
  logic        out_is_text_cell;
  logic [7:0]  out_text_code;
  logic [5:0]  out_text_column;
  logic [4:0]  out_text_row;
  logic        out_last;
  logic        cfg_write_enable = 1'b0;
  logic [2:0]  cfg_index = CFG_GRAPHICS;
  logic [0:0]  cfg_data = '0;

  video_write_pixel_render dut (.*);

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Shadow of the block: byte store and mode bits
  // ---------------------------------------------------------------------------
  logic [7:0] shadow_store [MEM_BYTES];
  vid_cfg_t   mode = '{graphics: 1'b0, hires: 1'b0, mixed: 1'b0, page: 1'b0, color: 1'b1};

  cpu_write_t     cpu_writes[$];     // writes still to be offered
  screen_update_t screen_updates[$]; // results still owed by the block

  int idle_pct  = 0;
  int stall_pct = 0;
  int errors    = 0;
  int cycles    = 0;

  logic [23:0] lores_pal [16] = '{24'h000000, 24'hE31E60, 24'h604EBD, 24'hFF44FD,
                                  24'h00A360, 24'h9C9C9C, 24'h14CFFD, 24'hD0C3FF,
                                  24'h607203, 24'hFF6A3C, 24'h9C9C9C, 24'hFFA0D0,
                                  24'h14F53C, 24'hD0DD8D, 24'h72FFD0, 24'hFFFFFF};
  logic [23:0] hires_pal [8]  = '{24'h000000, 24'h14F53C, 24'hFF44FD, 24'hFFFFFF,
                                  24'h000000, 24'hFF6A3C, 24'h14CFFD, 24'hFFFFFF};
  logic [23:0] grey_pal [4]   = '{24'h000000, 24'h555555, 24'hABABAB, 24'hFFFFFF};

  function automatic logic [23:0] fringe_colour(int unsigned win, bit odd, logic [7:0] owner);
    int unsigned hb;
    hb = owner[7] ? 4 : 0;
    case (win & 7)
      2:       return hires_pal[1 + (odd ? 0 : 1) + hb];
      5:       return hires_pal[1 + (odd ? 1 : 0) + hb];
      3, 6, 7: return hires_pal[3];
      default: return hires_pal[0];
    endcase
  endfunction

  function automatic logic [7:0] peek(int unsigned a);
    return (a < MEM_BYTES) ? shadow_store[a] : 8'h00;
  endfunction

  task automatic push_pixel(int unsigned x, int unsigned y, logic [23:0] rgb);
    screen_update_t u;
    u = '{x: x[8:0], y: y[7:0], r: rgb[23:16], g: rgb[15:8], b: rgb[7:0],
          txt: 1'b0, code: 8'h00, tcol: 6'd0, trow: 5'd0, last: 1'b0};
    screen_updates.push_back(u);
  endtask

  // Work out the results one accepted CPU write owes.
  task automatic render_write(logic [15:0] addr, logic [7:0] d);
    int unsigned a, c, col, grp, row, y, win, bx, owed;
    logic [7:0] dl, dr;
    logic [3:0] nib;
    screen_update_t u;
    bit odd;
    a = addr;
    owed = screen_updates.size();
    if (a >= MEM_BYTES || shadow_store[a] == d) return;
    shadow_store[a] = d;
    c = a & 'h7F;
    if (c >= 120) return;  // unused slots in each 128-byte group
    col = c % 40;
    grp = c / 40;
    if (a >= 'h400 && a < 'hC00) begin
      if ((a < 'h800) != (mode.page == 1'b0)) return;
      if (mode.graphics && mode.hires && !mode.mixed) return;
      row = ((a & 'h380) >> 7) + grp * 8;
      if (mode.graphics && mode.hires && row < 20) return;
      if (mode.graphics && (!mode.mixed || row < 20)) begin
        // 7x8 block: low nibble on top, high nibble below
        for (int yy = 0; yy < 8; yy++) begin
          nib = (yy < 4) ? d[3:0] : d[7:4];
          for (int xx = 0; xx < 7; xx++)
            push_pixel(col * 7 + xx, row * 8 + yy,
                       mode.color ? lores_pal[nib]
                                  : grey_pal[((xx + col) & 1) ? nib[1:0] : nib[3:2]]);
        end
      end else begin
        u = '{x: 9'd0, y: 8'd0, r: 8'd0, g: 8'd0, b: 8'd0, txt: 1'b1, code: d,
              tcol: col[5:0], trow: row[4:0], last: 1'b0};
        screen_updates.push_back(u);
      end
    end else if (a >= 'h2000 && a < 'h6000) begin
      if (!mode.hires || !mode.graphics) return;
      if ((a < 'h4000) != (mode.page == 1'b0)) return;
      y = (((a & 'h380) >> 4) | ((a & 'h1C00) >> 10)) + grp * 'h40;
      if (y >= 160 && mode.mixed) return;
      dl = (col == 0)  ? 8'h00 : peek(a - 1);
      dr = (col == 39) ? 8'h00 : peek(a + 1);
      bx = col * 7;
      odd = col[0];
      if (mode.color) begin
        // 11-bit window: two bits of the left byte, seven of ours, two of the right
        win = ((dl >> 5) & 'h3) | ((d << 2) & 'h1FC) | ((dr << 9) & 'h600);
        if (col != 0) push_pixel(bx - 1, y, fringe_colour(win, !odd, dl));
        win >>= 1;
        for (int xx = 0; xx < 7; xx++) begin
          push_pixel(bx + xx, y, fringe_colour(win, odd, d));
          win >>= 1;
          odd = !odd;
        end
        if (col < 39) push_pixel(bx + 7, y, fringe_colour(win, odd, dr));
      end else begin
        for (int xx = 0; xx < 7; xx++)
          push_pixel(bx + xx, y, d[xx] ? hires_pal[3] : hires_pal[0]);
      end
    end
    if (screen_updates.size() > owed)
      screen_updates[screen_updates.size() - 1].last = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Driver: one CPU write transaction offered at a time, random gaps
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    cpu_write_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) render_write(in_write_address, in_write_data);
      if (!in_valid || !in_stall) begin
        if (cpu_writes.size() > 0 && $urandom_range(99) >= idle_pct) begin
          nxt = cpu_writes.pop_front();
          in_valid         <= 1'b1;
          in_write_address <= nxt.addr;
          in_write_data    <= nxt.data;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver back-pressure
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // ---------------------------------------------------------------------------
  // Monitor: each result transaction against the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    screen_update_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (screen_updates.size() == 0) begin
        $error("unexpected result: x=%0d y=%0d text=%0d", out_pixel_x, out_pixel_y,
               out_is_text_cell);
        errors++;
      end else begin
        e = screen_updates.pop_front();
        if (out_pixel_x !== e.x) begin
          $error("pixel_x: expected %0d, got %0d", e.x, out_pixel_x); errors++;
        end
        if (out_pixel_y !== e.y) begin
          $error("pixel_y: expected %0d, got %0d", e.y, out_pixel_y); errors++;
        end
        if (out_red !== e.r) begin
          $error("red: expected %0d, got %0d", e.r, out_red); errors++;
        end
        if (out_green !== e.g) begin
          $error("green: expected %0d, got %0d", e.g, out_green); errors++;
        end
        if (out_blue !== e.b) begin
          $error("blue: expected %0d, got %0d", e.b, out_blue); errors++;
        end
        if (out_is_text_cell !== e.txt) begin
          $error("is_text_cell: expected %0d, got %0d", e.txt, out_is_text_cell); errors++;
        end
        if (out_text_code !== e.code) begin
          $error("text_code: expected %0d, got %0d", e.code, out_text_code); errors++;
        end
        if (out_text_column !== e.tcol) begin
          $error("text_column: expected %0d, got %0d", e.tcol, out_text_column); errors++;
        end
        if (out_text_row !== e.trow) begin
          $error("text_row: expected %0d, got %0d", e.trow, out_text_row); errors++;
        end
        if (out_last !== e.last) begin
          $error("last: expected %0d, got %0d", e.last, out_last); errors++;
        end
      end
    end
  end

  // watchdog; allows for the store clearing pass after reset
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencing
  // ---------------------------------------------------------------------------
  task automatic write_reg(logic [2:0] idx, logic v);
    @(posedge clk);
    cfg_write_enable <= 1'b1;
    cfg_index        <= idx;
    cfg_data         <= v;
    case (idx)
      CFG_GRAPHICS: mode.graphics = v;
      CFG_HIRES:    mode.hires    = v;
      CFG_MIXED:    mode.mixed    = v;
      CFG_PAGE:     mode.page     = v;
      default:      mode.color    = v;
    endcase
  endtask

  task automatic set_mode(vid_cfg_t m);
    write_reg(CFG_GRAPHICS, m.graphics);
    write_reg(CFG_HIRES, m.hires);
    write_reg(CFG_MIXED, m.mixed);
    write_reg(CFG_PAGE, m.page);
    write_reg(CFG_COLOR, m.color);
    @(posedge clk);
    cfg_write_enable <= 1'b0;
  endtask

  // block until everything offered has gone in and every result has come out
  task automatic drain();
    do @(negedge clk);
    while (cpu_writes.size() != 0 || in_valid || screen_updates.size() != 0);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic queue_write(int unsigned a, int unsigned d);
    cpu_write_t w;
    w.addr = a[15:0];
    w.data = d[7:0];
    cpu_writes.push_back(w);
  endtask

  initial begin
    vid_cfg_t    plan [7];
    int          idle_of [4]  = '{0, 50, 0, 36};
    int          stall_of [4] = '{0, 0, 50, 36};
    int unsigned text_base, hires_base, a, prev, pick;
    prev = 'h400;
    foreach (shadow_store[i]) shadow_store[i] = 8'h00;
    // graphics, hires, mixed, page, colour
    plan[0] = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b1};  // text, page one
    plan[1] = '{1'b1, 1'b0, 1'b0, 1'b0, 1'b1};  // lores colour
    plan[2] = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0};  // lores grey, mixed, page two
    plan[3] = '{1'b1, 1'b1, 1'b0, 1'b0, 1'b1};  // hires colour
    plan[4] = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b1};  // hires colour, mixed, page two
    plan[5] = '{1'b1, 1'b1, 1'b0, 1'b0, 1'b0};  // hires mono
    plan[6] = '{1'b0, 1'b1, 1'b1, 1'b1, 1'b0};  // text, page two

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    for (int ph = 0; ph < 7; ph++) begin
      set_mode(plan[ph]);
      @(negedge clk);
      idle_pct  = idle_of[ph % 4];
      stall_pct = stall_of[ph % 4];
      text_base  = mode.page ? 'h800 : 'h400;
      hires_base = mode.page ? 'h4000 : 'h2000;

      // directed: left and right edge columns, an unused slot, extreme data
      queue_write(text_base, 'hFF);
      queue_write(text_base + 'h3A7, 'h80);       // row 7, column 39
      queue_write(hires_base, 'hFF);
      queue_write(hires_base + 'h1FA7, 'hD5);     // column 39 of scanline 63
      queue_write(hires_base + 'h78 + ph, 'h55);  // unused slot
      if (ph == 0) begin
        queue_write('hFFFF, 'hAA);                // outside the store
        queue_write(text_base, 'hFF);             // same byte again
        queue_write('h0C00, 'h01);                // between the two regions
        queue_write('h0800, 'h7E);                // off the selected page
      end

      for (int i = 0; i < RAND_PER_PHASE; i++) begin
        pick = $urandom_range(99);
        if (pick < 40)       a = hires_base + $urandom_range('h1FFF);
        else if (pick < 70)  a = text_base + $urandom_range('h3FF);
        else if (pick < 85)  a = (prev & 'h7F) == 0 ? prev + 1 : prev - 1 + 2 * $urandom_range(1);
        else                 a = $urandom_range('hFFFF);
        prev = a;
        queue_write(a, $urandom_range(255));
        // follow with a neighbour so hires fringes see non-zero bytes
        if ($urandom_range(3) == 0) queue_write(a + 1, $urandom_range(255));
      end
      drain();
    end

    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
